/* sv/odometer_wear_leveled_log_defines.svh */
// ---------------------------------------------------------------------------
// odometer_wear_leveled_log_defines.svh
// Assertion macros shared by the odometer log RTL.
// ---------------------------------------------------------------------------
`ifndef ODOMETER_WEAR_LEVELED_LOG_DEFINES_SVH
`define ODOMETER_WEAR_LEVELED_LOG_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every edge out of reset
`define OWL_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("owlog check failed");

// same-cycle implication
`define OWL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("owlog check failed");

// next-cycle implication
`define OWL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("owlog check failed");

`else

`define OWL_ASSERT_HOLDS(label, clk, rst, prop)
`define OWL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OWL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/owlog_pkg.sv */
// ---------------------------------------------------------------------------
// owlog_pkg
// Types and constants of the wear-leveled odometer log.
// ---------------------------------------------------------------------------
package owlog_pkg;

   localparam int LOG_START = 32;
   localparam int LOG_END   = 1024;
   localparam int MEM_DEPTH = 1024;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   typedef logic [ADDR_W-1:0] offset_type;
   typedef logic [ADDR_W:0]   index_type;    // one bit more, holds LOG_END
   typedef logic [7:0]        byte_type;
   typedef logic [14:0]       record_type;
   typedef logic [22:0]       mileage_type;
   typedef logic [7:0]        count_type;

   localparam offset_type  START_OFS   = offset_type'(LOG_START);
   localparam offset_type  LAST_OFS    = offset_type'(LOG_END - 2);
   localparam index_type   START_IDX   = index_type'(LOG_START);
   localparam index_type   END_IDX     = index_type'(LOG_END);
   localparam index_type   LAST_IDX    = index_type'(LOG_END - 2);
   localparam offset_type  ADDR_LAST   = offset_type'(MEM_DEPTH - 1);
   localparam byte_type    END_MARK    = 8'h80;
   localparam mileage_type MILEAGE_MAX = 23'h7fffff;

   typedef enum logic [2:0] {
      MODE_SCAN      = 3'd0,
      MODE_ADD       = 3'd1,
      MODE_COMMIT    = 3'd2,
      MODE_SET       = 3'd3,
      MODE_TRIP_ONE  = 3'd4,
      MODE_TRIP_TWO  = 3'd5,
      MODE_INIT      = 3'd6,
      MODE_NOP       = 3'd7
   } mode_type;

   // one byte write into the log store
   typedef struct packed {
      logic       en;
      offset_type addr;
      byte_type   data;
   } mem_wr_type;

endpackage

/* sv/owlog_ram.sv */
// ---------------------------------------------------------------------------
// owlog_ram
// Log byte store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module owlog_ram (
   input  logic                   clock,
   input  owlog_pkg::mem_wr_type  wr_req,
   input  owlog_pkg::offset_type  rd_addr0,
   input  owlog_pkg::offset_type  rd_addr1,
   output owlog_pkg::byte_type    rd_data0,
   output owlog_pkg::byte_type    rd_data1
);
   import owlog_pkg::*;

   byte_type log_mem_ff [MEM_DEPTH];
   byte_type rd_data0_ff;
   byte_type rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         log_mem_ff[wr_req.addr] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data0_ff <= log_mem_ff[rd_addr0];
      rd_data1_ff <= log_mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

/* sv/odometer_wear_leveled_log.sv */
// odometer_wear_leveled_log: odometer kept as a ring of 2-byte records in a byte store.
// Add, trip reset, no-op: result registered from RESP; next item taken only once the result is loaded.
// Commit/set with a record: high byte, low byte, end marker, last-slot clear on ring wrap; single write port.
// Scan: a record read and marker test per record walked; initialize: full-store clear, then the result.
// Reset (sync): a clearing pass over all 1024 bytes of the store runs with req_stall high.
`include "odometer_wear_leveled_log_defines.svh"

module odometer_wear_leveled_log (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_mode,
   input  logic [15:0]            req_distance,
   input  owlog_pkg::mileage_type req_new_mileage,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output owlog_pkg::mileage_type rsp_total_mileage,
   output owlog_pkg::mileage_type rsp_trip_one,
   output owlog_pkg::mileage_type rsp_trip_two,
   output owlog_pkg::offset_type  rsp_next_offset,
   output owlog_pkg::count_type   rsp_high_count,
   output logic                   rsp_record_written,
   output logic                   rsp_header_written
);
   import owlog_pkg::*;

   // Sequencer. Every item is taken in IDLE only; the result is built in RESP
   // and parked in the output register, so the next item can be taken while
   // the previous result is still waiting for the consumer.
   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,   // sweep zeros through the whole store
      S_IDLE     = 9'b000000010,
      S_SCAN_RD  = 9'b000000100,   // read the record pair at scan_idx
      S_SCAN_CHK = 9'b000001000,   // marker test on returned bytes
      S_APP_HI   = 9'b000010000,   // high byte; also read the last slot
      S_APP_LO   = 9'b000100000,   // low byte; wrap test on last slot
      S_APP_MK   = 9'b001000000,   // end marker; advance write offset
      S_APP_CLR  = 9'b010000000,   // drop the stale marker in the last slot
      S_RESP     = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;

   // odometer state (header and ring pointer)
   offset_type  wo_ff, wo_in;                 // next record offset
   record_type  latest_ff, latest_in;
   mileage_type mileage_now_ff, mileage_now_in;
   mileage_type mileage_saved_ff, mileage_saved_in;
   count_type   mult_ff, mult_in;
   count_type   trip_mult_ff [2];
   count_type   trip_mult_in [2];
   record_type  trip_mark_ff [2];
   record_type  trip_mark_in [2];

   // sequencing
   offset_type  clr_cnt_ff, clr_cnt_in;
   logic        init_pend_ff, init_pend_in;   // clear pass answers an initialize
   index_type   scan_idx_ff, scan_idx_in;
   logic        clr_need_ff, clr_need_in;
   logic        rec_ff, rec_in;
   logic        hdr_ff, hdr_in;

   // store ports
   mem_wr_type  wr_req;
   offset_type  rd_addr0;
   offset_type  rd_addr1;
   byte_type    rd_data0;
   byte_type    rd_data1;

   // response register
   logic        rsp_valid_ff;
   mileage_type rsp_total_ff;
   mileage_type rsp_trip_one_ff;
   mileage_type rsp_trip_two_ff;
   offset_type  rsp_offset_ff;
   count_type   rsp_count_ff;
   logic        rsp_rec_ff;
   logic        rsp_hdr_ff;
   logic        rsp_load;

   logic        req_take;

   // check terms
   logic        ofs_ok;
   logic        saved_ok;
   logic        trip_ok;
   logic        scan_ok;

   owlog_ram u_ram (
      .clock    (clock),
      .wr_req   (wr_req),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // distance from a trip marker, floored at zero
   function automatic mileage_type trip_dist(mileage_type now, count_type m, record_type r);
      logic [23:0] diff;
      diff = {1'b0, now} - {1'b0, m, r};
      return diff[23] ? '0 : diff[22:0];
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   // Scan reads the record pair on both ports; append checks the last slot
   // for a marker left over from the previous lap of the ring.
   assign rd_addr0 = (state_ff == S_SCAN_RD) ? scan_idx_ff[ADDR_W-1:0] : LAST_OFS;
   assign rd_addr1 = scan_idx_ff[ADDR_W-1:0] + offset_type'(1);

   always_comb begin
      logic [23:0] sum_v;
      record_type  lat_v;
      index_type   idx_v;
      logic        done_v;
      index_type   adv_v;

      state_in         = state_ff;
      wo_in            = wo_ff;
      latest_in        = latest_ff;
      mileage_now_in   = mileage_now_ff;
      mileage_saved_in = mileage_saved_ff;
      mult_in          = mult_ff;
      trip_mult_in     = trip_mult_ff;
      trip_mark_in     = trip_mark_ff;
      clr_cnt_in       = clr_cnt_ff;
      init_pend_in     = init_pend_ff;
      scan_idx_in      = scan_idx_ff;
      clr_need_in      = clr_need_ff;
      rec_in           = rec_ff;
      hdr_in           = hdr_ff;
      wr_req           = '0;

      sum_v  = {1'b0, mileage_now_ff} + {8'd0, req_distance};
      lat_v  = latest_ff;
      idx_v  = scan_idx_ff;
      done_v = 1'b0;
      adv_v  = {1'b0, wo_ff} + index_type'(2);

      case (state_ff)
         S_CLEAR: begin
            wr_req.en   = 1'b1;
            wr_req.addr = clr_cnt_ff;
            wr_req.data = '0;
            clr_cnt_in  = clr_cnt_ff + offset_type'(1);
            if (clr_cnt_ff == ADDR_LAST) begin
               state_in     = init_pend_ff ? S_RESP : S_IDLE;
               init_pend_in = 1'b0;
            end
         end

         S_IDLE: begin
            if (req_take) begin
               rec_in   = 1'b0;
               hdr_in   = 1'b0;
               state_in = S_RESP;
               case (mode_type'(req_mode))
                  MODE_SCAN: begin
                     scan_idx_in = START_IDX;
                     state_in    = S_SCAN_RD;
                  end
                  MODE_ADD: begin
                     mileage_now_in = sum_v[23] ? MILEAGE_MAX : sum_v[22:0];
                  end
                  MODE_COMMIT: begin
                     if (mileage_now_ff != mileage_saved_ff) begin
                        if (mileage_now_ff[22:15] != mult_ff) begin
                           mult_in = mileage_now_ff[22:15];
                           hdr_in  = 1'b1;
                        end
                        latest_in        = mileage_now_ff[14:0];
                        mileage_saved_in = mileage_now_ff;
                        rec_in           = 1'b1;
                        state_in         = S_APP_HI;
                     end
                  end
                  MODE_SET: begin
                     mileage_now_in   = req_new_mileage;
                     mileage_saved_in = req_new_mileage;
                     latest_in        = req_new_mileage[14:0];
                     mult_in          = req_new_mileage[22:15];
                     trip_mult_in[0]  = req_new_mileage[22:15];
                     trip_mult_in[1]  = req_new_mileage[22:15];
                     trip_mark_in[0]  = req_new_mileage[14:0];
                     trip_mark_in[1]  = req_new_mileage[14:0];
                     rec_in           = 1'b1;
                     hdr_in           = 1'b1;
                     state_in         = S_APP_HI;
                  end
                  MODE_TRIP_ONE: begin
                     trip_mult_in[0] = mileage_now_ff[22:15];
                     trip_mark_in[0] = mileage_now_ff[14:0];
                     hdr_in          = 1'b1;
                  end
                  MODE_TRIP_TWO: begin
                     trip_mult_in[1] = mileage_now_ff[22:15];
                     trip_mark_in[1] = mileage_now_ff[14:0];
                     hdr_in          = 1'b1;
                  end
                  MODE_INIT: begin
                     mult_in          = '0;
                     trip_mult_in[0]  = '0;
                     trip_mult_in[1]  = '0;
                     trip_mark_in[0]  = '0;
                     trip_mark_in[1]  = '0;
                     mileage_now_in   = '0;
                     mileage_saved_in = '0;
                     latest_in        = '0;
                     wo_in            = START_OFS;
                     hdr_in           = 1'b1;
                     clr_cnt_in       = '0;
                     init_pend_in     = 1'b1;
                     state_in         = S_CLEAR;
                  end
                  default: begin
                     // no operation
                  end
               endcase
            end
         end

         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end

         S_SCAN_CHK: begin
            if (rd_data0[7]) begin
               done_v = 1'b1;
            end else begin
               lat_v = {rd_data0[6:0], rd_data1};
               idx_v = scan_idx_ff + index_type'(2);
               if (idx_v >= END_IDX) begin
                  // no marker anywhere: blank log
                  lat_v  = '0;
                  idx_v  = START_IDX;
                  done_v = 1'b1;
               end
            end
            latest_in   = lat_v;
            scan_idx_in = idx_v;
            if (done_v) begin
               // marker in the last slot resumes at the ring start
               wo_in            = (idx_v >= LAST_IDX) ? START_OFS : idx_v[ADDR_W-1:0];
               mileage_now_in   = {mult_ff, lat_v};
               mileage_saved_in = {mult_ff, lat_v};
               state_in         = S_RESP;
            end else begin
               state_in = S_SCAN_RD;
            end
         end

         S_APP_HI: begin
            wr_req.en   = 1'b1;
            wr_req.addr = wo_ff;
            wr_req.data = {1'b0, latest_ff[14:8]};
            state_in    = S_APP_LO;
         end

         S_APP_LO: begin
            wr_req.en   = 1'b1;
            wr_req.addr = wo_ff + offset_type'(1);
            wr_req.data = latest_ff[7:0];
            clr_need_in = (wo_ff == START_OFS) && (rd_data0 == END_MARK);
            state_in    = S_APP_MK;
         end

         S_APP_MK: begin
            wr_req.en   = 1'b1;
            wr_req.addr = wo_ff + offset_type'(2);
            wr_req.data = END_MARK;
            wo_in       = (adv_v >= LAST_IDX) ? START_OFS : adv_v[ADDR_W-1:0];
            state_in    = clr_need_ff ? S_APP_CLR : S_RESP;
         end

         S_APP_CLR: begin
            wr_req.en   = 1'b1;
            wr_req.addr = LAST_OFS;
            wr_req.data = '0;
            state_in    = S_RESP;
         end

         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         wo_ff            <= START_OFS;
         latest_ff        <= '0;
         mileage_now_ff   <= '0;
         mileage_saved_ff <= '0;
         mult_ff          <= '0;
         trip_mult_ff[0]  <= '0;
         trip_mult_ff[1]  <= '0;
         trip_mark_ff[0]  <= '0;
         trip_mark_ff[1]  <= '0;
         clr_cnt_ff       <= '0;
         init_pend_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         wo_ff            <= wo_in;
         latest_ff        <= latest_in;
         mileage_now_ff   <= mileage_now_in;
         mileage_saved_ff <= mileage_saved_in;
         mult_ff          <= mult_in;
         trip_mult_ff     <= trip_mult_in;
         trip_mark_ff     <= trip_mark_in;
         clr_cnt_ff       <= clr_cnt_in;
         init_pend_ff     <= init_pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sequencing payload, no reset needed
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      clr_need_ff <= clr_need_in;
      rec_ff      <= rec_in;
      hdr_ff      <= hdr_in;
   end

   // result register: trip distances come from the settled state
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_total_ff    <= mileage_now_ff;
         rsp_trip_one_ff <= trip_dist(mileage_now_ff, trip_mult_ff[0], trip_mark_ff[0]);
         rsp_trip_two_ff <= trip_dist(mileage_now_ff, trip_mult_ff[1], trip_mark_ff[1]);
         rsp_offset_ff   <= wo_ff;
         rsp_count_ff    <= mult_ff;
         rsp_rec_ff      <= rec_ff;
         rsp_hdr_ff      <= hdr_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_mileage  = rsp_total_ff;
   assign rsp_trip_one       = rsp_trip_one_ff;
   assign rsp_trip_two       = rsp_trip_two_ff;
   assign rsp_next_offset    = rsp_offset_ff;
   assign rsp_high_count     = rsp_count_ff;
   assign rsp_record_written = rsp_rec_ff;
   assign rsp_header_written = rsp_hdr_ff;

   assign ofs_ok   = (wo_ff >= START_OFS) && !wo_ff[0] && ({1'b0, wo_ff} < LAST_IDX);
   assign saved_ok = (mileage_saved_ff == mileage_now_ff);
   assign trip_ok  = (rsp_trip_one <= rsp_total_mileage) && (rsp_trip_two <= rsp_total_mileage);
   assign scan_ok  = (scan_idx_ff < END_IDX) && !scan_idx_ff[0];

   // write offset always sits on an even slot inside the ring
   `OWL_ASSERT_HOLDS(a_offset_legal, clock, reset, ofs_ok)
   // a step that appended a record leaves the saved mileage in step
   `OWL_ASSERT_IMPL(a_rec_saved, clock, reset, (state_ff == S_RESP) && rec_ff, saved_ok)
   // trip distances never exceed the total
   `OWL_ASSERT_IMPL(a_trip_bound, clock, reset, rsp_valid, trip_ok)
   // scan walks record pairs inside the ring
   `OWL_ASSERT_IMPL(a_scan_idx, clock, reset, state_ff == S_SCAN_RD, scan_ok)

endmodule

/* verif/odometer_wear_leveled_log_tb.sv */
// ---------------------------------------------------------------------------
// odometer_wear_leveled_log_tb
// Self-checking bench for the wear-leveled odometer log. A short table of
// directed transfers covers every mode and the corner cases, then random
// sequences fill the record ring past its wrap point. Every response is
// compared field by field with a hand-written answer or in-bench log model.
// Both ends idle and stall at random, with one long receiver hold-off.
// ---------------------------------------------------------------------------
module odometer_wear_leveled_log_tb;
   import owlog_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int REPORT_MAX  = 10;
   localparam int PLAN_LEN    = 25;

   // one response of the block
   typedef struct packed {
      mileage_type total;
      mileage_type trip1;
      mileage_type trip2;
      offset_type  ofs;
      count_type   hc;
      logic        rec;
      logic        hdr;
   } reading_type;

   typedef struct {
      mode_type    mode;
      logic [15:0] delta;
      mileage_type nm;
      bit          typed;   // want holds a hand-written response
      reading_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = MODE_NOP;
   logic [15:0] req_distance = '0;
   mileage_type req_new_mileage = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mileage_type rsp_total_mileage;
   mileage_type rsp_trip_one;
   mileage_type rsp_trip_two;
   offset_type  rsp_next_offset;
   count_type   rsp_high_count;
   logic        rsp_record_written;
   logic        rsp_header_written;

   odometer_wear_leveled_log u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_distance       (req_distance),
      .req_new_mileage    (req_new_mileage),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_mileage  (rsp_total_mileage),
      .rsp_trip_one       (rsp_trip_one),
      .rsp_trip_two       (rsp_trip_two),
      .rsp_next_offset    (rsp_next_offset),
      .rsp_high_count     (rsp_high_count),
      .rsp_record_written (rsp_record_written),
      .rsp_header_written (rsp_header_written)
   );

   // ------------------------------------------------------------------
   // Log model: byte image of the store plus header registers
   // ------------------------------------------------------------------
   byte_type    log_image [MEM_DEPTH];
   offset_type  wr_ofs = START_OFS;
   record_type  last_rec = '0;
   mileage_type odo_now = '0;
   mileage_type odo_saved = '0;
   count_type   hi_now = '0;
   count_type   trip_hi [2] = '{8'd0, 8'd0};
   record_type  trip_lo [2] = '{15'd0, 15'd0};
   bit          ring_wrapped = 1'b0;

   reading_type pending_readings [$];
   int          fail_count = 0;
   int          readings_seen = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 37;
   int          recv_idle_pct = 50;
   logic        hold_off = 1'b0;
   logic        rand_started = 1'b0;
   plan_row_type plan [PLAN_LEN];

   initial begin
      foreach (log_image[i]) log_image[i] = '0;
   end

   function automatic void log_append(record_type r);
      int p;
      p = int'(wr_ofs);
      last_rec = r;
      if (p == LOG_START && log_image[LAST_OFS] == END_MARK)
         log_image[LAST_OFS] = '0;
      log_image[offset_type'(p)]     = {1'b0, r[14:8]};
      log_image[offset_type'(p + 1)] = r[7:0];
      log_image[offset_type'(p + 2)] = END_MARK;
      p += 2;
      if (p >= LOG_END - 2) begin
         p = LOG_START;
         ring_wrapped = 1'b1;
      end
      wr_ofs = offset_type'(p);
   endfunction

   function automatic void log_scan();
      int i;
      i = LOG_START;
      while (i < LOG_END && !log_image[offset_type'(i)][7]) begin
         last_rec = {log_image[offset_type'(i)][6:0], log_image[offset_type'(i + 1)]};
         i += 2;
      end
      if (i >= LOG_END) begin
         // blank log: no end marker anywhere
         last_rec = '0;
         i = LOG_START;
      end else if (i >= LOG_END - 2) begin
         // marker in the last slot, writing resumes at the ring start
         i = LOG_START;
      end
      wr_ofs    = offset_type'(i);
      odo_now   = {hi_now, last_rec};
      odo_saved = odo_now;
   endfunction

   function automatic mileage_type trip_reading(bit k);
      mileage_type mark;
      mark = {trip_hi[k], trip_lo[k]};
      return (odo_now >= mark) ? odo_now - mark : '0;
   endfunction

   function automatic reading_type odometer_step(mode_type m, logic [15:0] delta,
                                                 mileage_type nm);
      reading_type r;
      logic [23:0] sum;
      int          k;
      bit          sel;
      r = '0;
      case (m)
         MODE_SCAN: log_scan();
         MODE_ADD: begin
            sum = {1'b0, odo_now} + 24'(delta);
            odo_now = (sum > 24'(MILEAGE_MAX)) ? MILEAGE_MAX : sum[22:0];
         end
         MODE_COMMIT: begin
            if (odo_now != odo_saved) begin
               if (odo_now[22:15] != hi_now) begin
                  hi_now = odo_now[22:15];
                  r.hdr = 1'b1;
               end
               log_append(odo_now[14:0]);
               odo_saved = odo_now;
               r.rec = 1'b1;
            end
         end
         MODE_SET: begin
            odo_now   = nm;
            odo_saved = nm;
            log_append(nm[14:0]);
            hi_now  = nm[22:15];
            trip_hi = '{nm[22:15], nm[22:15]};
            trip_lo = '{nm[14:0], nm[14:0]};
            r.rec = 1'b1;
            r.hdr = 1'b1;
         end
         MODE_TRIP_ONE, MODE_TRIP_TWO: begin
            sel = (m == MODE_TRIP_TWO);
            trip_hi[sel] = odo_now[22:15];
            trip_lo[sel] = odo_now[14:0];
            r.hdr = 1'b1;
         end
         MODE_INIT: begin
            hi_now  = '0;
            trip_hi = '{8'd0, 8'd0};
            trip_lo = '{15'd0, 15'd0};
            for (k = LOG_START; k < LOG_END; k++) log_image[offset_type'(k)] = '0;
            odo_now   = '0;
            odo_saved = '0;
            last_rec  = '0;
            wr_ofs    = START_OFS;
            r.hdr = 1'b1;
         end
         default: ;
      endcase
      r.total = odo_now;
      r.trip1 = trip_reading(1'b0);
      r.trip2 = trip_reading(1'b1);
      r.ofs   = wr_ofs;
      r.hc    = hi_now;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Random field values, biased toward the edges
   // ------------------------------------------------------------------
   function automatic logic [15:0] pick_distance();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hffff;
         2, 3, 4: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 300));
      endcase
   endfunction

   function automatic mileage_type pick_mileage();
      case ($urandom_range(0, 5))
         0:       return MILEAGE_MAX - mileage_type'($urandom_range(0, 70000));
         1:       return {count_type'($urandom_range(0, 255)),
                          15'h7fff - 15'($urandom_range(0, 40))};
         2:       return mileage_type'($urandom_range(0, 1000));
         default: return mileage_type'($urandom_range(0, 8388607));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic issue(input mode_type m, input logic [15:0] d, input mileage_type nm,
                        input bit typed, input reading_type want);
      reading_type model_out;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= m;
      req_distance    <= d;
      req_new_mileage <= nm;
      do @(posedge clock); while (!(req_valid && !req_stall));
      model_out = odometer_step(m, d, nm);
      pending_readings.push_back(typed ? want : model_out);
      if (m != MODE_NOP) items_sent++;
   endtask

   task automatic issue_rand(input mode_type m);
      issue(m, pick_distance(), pick_mileage(), 1'b0, '0);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // long receiver hold-off at the start of the random part; the block
   // fills up and must push back on the request side
   initial begin
      wait (rand_started);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      int       n;
      int       r;
      int       phase;
      int       wrap_mark;
      mode_type pick;
      plan = '{
         // blank log scan straight after reset
         '{MODE_SCAN, 16'd0, 23'd0, 1'b1,
           '{23'd0, 23'd0, 23'd0, START_OFS, 8'd0, 1'b0, 1'b0}},
         // unused mode, payload at its extremes
         '{MODE_NOP, 16'hffff, MILEAGE_MAX, 1'b1,
           '{23'd0, 23'd0, 23'd0, START_OFS, 8'd0, 1'b0, 1'b0}},
         '{MODE_ADD, 16'hffff, 23'd0, 1'b1,
           '{23'd65535, 23'd65535, 23'd65535, START_OFS, 8'd0, 1'b0, 1'b0}},
         // first commit raises the multiplier to one
         '{MODE_COMMIT, 16'd0, 23'd0, 1'b1,
           '{23'd65535, 23'd65535, 23'd65535, offset_type'(LOG_START + 2), 8'd1,
             1'b1, 1'b1}},
         '{MODE_COMMIT, 16'd0, 23'd0, 1'b0, '0},
         '{MODE_TRIP_ONE, 16'd0, 23'd0, 1'b0, '0},
         '{MODE_ADD, 16'd0, 23'd0, 1'b0, '0},
         '{MODE_SET, 16'd0, MILEAGE_MAX, 1'b1,
           '{MILEAGE_MAX, 23'd0, 23'd0, offset_type'(LOG_START + 4), 8'd255,
             1'b1, 1'b1}},
         // saturation, then a commit with nothing new
         '{MODE_ADD, 16'hffff, 23'd0, 1'b0, '0},
         '{MODE_COMMIT, 16'd0, 23'd0, 1'b0, '0},
         // trip markers above a rescanned mileage read zero
         '{MODE_SET, 16'd0, 23'd100, 1'b0, '0},
         '{MODE_ADD, 16'd1000, 23'd0, 1'b0, '0},
         '{MODE_TRIP_ONE, 16'd0, 23'd0, 1'b0, '0},
         '{MODE_TRIP_TWO, 16'd0, 23'd0, 1'b0, '0},
         '{MODE_SCAN, 16'd0, 23'd0, 1'b0, '0},
         // cross a 32768 boundary and commit it
         '{MODE_ADD, 16'd32668, 23'd0, 1'b0, '0},
         '{MODE_COMMIT, 16'd0, 23'd0, 1'b0, '0},
         '{MODE_SET, 16'h5555, 23'h2aaaaa, 1'b0, '0},
         '{MODE_SET, 16'haaaa, 23'h555555, 1'b0, '0},
         '{MODE_ADD, 16'h5555, 23'h555555, 1'b0, '0},
         '{MODE_ADD, 16'haaaa, 23'h2aaaaa, 1'b0, '0},
         '{MODE_COMMIT, 16'd0, 23'd0, 1'b0, '0},
         '{MODE_INIT, 16'd0, 23'd0, 1'b1,
           '{23'd0, 23'd0, 23'd0, START_OFS, 8'd0, 1'b0, 1'b1}},
         '{MODE_SCAN, 16'd0, 23'd0, 1'b1,
           '{23'd0, 23'd0, 23'd0, START_OFS, 8'd0, 1'b0, 1'b0}},
         '{MODE_TRIP_TWO, 16'd0, 23'd0, 1'b0, '0}
      };
      phase     = 1;
      wrap_mark = 0;

      do @(posedge clock); while (reset);

      foreach (plan[i])
         issue(plan[i].mode, plan[i].delta, plan[i].nm, plan[i].typed, plan[i].want);

      // Random part. Until the ring has wrapped, mostly appends so the
      // wrap and the last-slot marker get reached; afterward a full mix.
      rand_started <= 1'b1;
      n = 0;
      while ((!ring_wrapped || items_sent < wrap_mark + 40) && n < 1500) begin
         n++;
         if (phase == 1 && items_sent >= 200) begin
            phase = 2;
            send_idle_pct = 50;
            recv_idle_pct <= 37;
         end else if (phase == 2 && items_sent >= 400) begin
            phase = 3;
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         if (ring_wrapped && wrap_mark == 0) wrap_mark = items_sent;
         r = $urandom_range(0, 99);
         if (wr_ofs == START_OFS && log_image[LAST_OFS] == END_MARK && r < 60) begin
            // marker sits in the last slot right now
            issue_rand(MODE_SCAN);
         end else if (!ring_wrapped) begin
            if (r < 92) begin
               issue_rand(MODE_SET);
            end else if (r < 96) begin
               issue_rand(MODE_ADD);
               issue_rand(MODE_COMMIT);
            end else begin
               case ($urandom_range(0, 5))
                  0:       pick = MODE_ADD;
                  1:       pick = MODE_COMMIT;
                  2:       pick = MODE_TRIP_ONE;
                  3:       pick = MODE_TRIP_TWO;
                  4:       pick = MODE_SCAN;
                  default: pick = MODE_NOP;
               endcase
               issue_rand(pick);
            end
         end else begin
            if (r < 20) begin
               issue_rand(MODE_ADD);
               issue_rand(MODE_COMMIT);
            end else if (r < 35) begin
               issue_rand(MODE_SET);
            end else if (r < 47) begin
               issue_rand(MODE_ADD);
            end else if (r < 57) begin
               issue_rand(MODE_COMMIT);
            end else if (r < 64) begin
               issue_rand(MODE_TRIP_ONE);
            end else if (r < 71) begin
               issue_rand(MODE_TRIP_TWO);
            end else if (r < 79) begin
               issue_rand(MODE_SCAN);
            end else if (r < 82) begin
               issue_rand(MODE_INIT);
            end else if (r < 90) begin
               issue_rand(MODE_NOP);
            end else begin
               issue(MODE_ADD, 16'hffff, pick_mileage(), 1'b0, '0);
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side: check each transfer, then pick the next stall
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want_v,
                                       logic [31:0] got_v);
      if (got_v !== want_v) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("reading %0d: %s expected %0d, got %0d",
                     readings_seen, name, want_v, got_v);
      end
   endfunction

   initial begin
      reading_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            readings_seen++;
            if (pending_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("reading %0d arrived with nothing pending", readings_seen);
            end else begin
               want = pending_readings.pop_front();
               check_field("total_mileage",  32'(want.total), 32'(rsp_total_mileage));
               check_field("trip_one",       32'(want.trip1), 32'(rsp_trip_one));
               check_field("trip_two",       32'(want.trip2), 32'(rsp_trip_two));
               check_field("next_offset",    32'(want.ofs),   32'(rsp_next_offset));
               check_field("high_count",     32'(want.hc),    32'(rsp_high_count));
               check_field("record_written", 32'(want.rec),   32'(rsp_record_written));
               check_field("header_written", 32'(want.hdr),   32'(rsp_header_written));
            end
         end
         if (hold_off)
            rsp_stall <= 1'b1;
         else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
            rsp_stall <= 1'b1;
         else
            rsp_stall <= 1'b0;
      end
   end

   // watchdog
   initial begin
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/owlog_pkg.sv
sv/owlog_ram.sv
sv/odometer_wear_leveled_log.sv
verif/odometer_wear_leveled_log_tb.sv
